// ----- rtl/rgbc_lux_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbc_lux_pkg
// Shared widths, reset values, register indexes and stage types for the
// RGBC illuminance block with automatic gain ranging.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbc_lux_pkg;

  localparam int COUNT_W = 16;
  localparam int COEF_W  = 15;
  localparam int THR_W   = 16;
  localparam int GAIN_W  = 2;
  localparam int LUX_W   = 22;
  localparam int PROD_W  = COUNT_W + 1 + COEF_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int Q_SHIFT = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] GAIN_MIN = 2'd0;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 2'd3;

  localparam logic signed [COEF_W-1:0] COEF_RED_RST   = 15'sd415;
  localparam logic signed [COEF_W-1:0] COEF_GREEN_RST = 15'sd4728;
  localparam logic signed [COEF_W-1:0] COEF_BLUE_RST  = 15'sd79;
  localparam logic signed [COEF_W-1:0] COEF_CLEAR_RST = -15'sd8173;
  localparam logic [THR_W-1:0]         LOW_THR_RST    = 16'd8191;
  localparam logic [THR_W-1:0]         HIGH_THR_RST   = 16'd49151;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_RED   = 3'd0,
    CFG_COEF_GREEN = 3'd1,
    CFG_COEF_BLUE  = 3'd2,
    CFG_COEF_CLEAR = 3'd3,
    CFG_LOW_THR    = 3'd4,
    CFG_HIGH_THR   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_red;
    logic signed [COEF_W-1:0] coef_green;
    logic signed [COEF_W-1:0] coef_blue;
    logic signed [COEF_W-1:0] coef_clear;
    logic [THR_W-1:0]         low_threshold;
    logic [THR_W-1:0]         high_threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod_red;
    logic signed [PROD_W-1:0] prod_green;
    logic signed [PROD_W-1:0] prod_blue;
    logic signed [PROD_W-1:0] prod_clear;
    logic [GAIN_W-1:0]        gain_used;
    logic [GAIN_W-1:0]        gain_next;
  } prod_t;

endpackage

`default_nettype wire

// ----- rtl/rgbc_lux_if.sv -----
// ----------------------------------------------------------------------------
// rgbc_lux_if
// Valid/ready channels for RGBC samples and lux results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgbc_lux_in_if
  import rgbc_lux_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] red_count;
  logic [COUNT_W-1:0] green_count;
  logic [COUNT_W-1:0] blue_count;
  logic [COUNT_W-1:0] clear_count;
  logic               saturated;

  modport source (
    output valid, red_count, green_count, blue_count, clear_count, saturated,
    input  ready
  );
  modport sink (
    input  valid, red_count, green_count, blue_count, clear_count, saturated,
    output ready
  );
endinterface

interface rgbc_lux_out_if
  import rgbc_lux_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [LUX_W-1:0]  lux_value;
  logic [GAIN_W-1:0] gain_used;
  logic [GAIN_W-1:0] gain_next;

  modport source (
    output valid, lux_value, gain_used, gain_next,
    input  ready
  );
  modport sink (
    input  valid, lux_value, gain_used, gain_next,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/rgbc_lux_front.sv -----
// ----------------------------------------------------------------------------
// rgbc_lux_front
// Input register, gain ranging and the four weighted-channel products.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbc_lux_front
  import rgbc_lux_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  rgbc_lux_in_if.sink  in_ch,
  input  wire cfg_t    cfg,
  output logic         prod_valid,
  output prod_t        prod,
  input  wire logic    prod_ready
);

  logic               s1_valid_r;
  logic [COUNT_W-1:0] s1_red_r;
  logic [COUNT_W-1:0] s1_green_r;
  logic [COUNT_W-1:0] s1_blue_r;
  logic [COUNT_W-1:0] s1_clear_r;
  logic               s1_sat_r;
  logic [GAIN_W-1:0]  gain_code_r;
  logic [GAIN_W-1:0]  gain_code_nxt;
  logic               prod_valid_r;
  prod_t              prod_r;
  prod_t              prod_nxt;
  logic               s2_free;
  logic               s1_move;
  logic               s1_free;
  logic [COUNT_W-1:0] max_rg;
  logic [COUNT_W-1:0] max_rgb;
  logic               raise;
  logic               lower;

  assign s2_free     = !prod_valid_r || prod_ready;
  assign s1_move     = s1_valid_r && s2_free;
  assign s1_free     = !s1_valid_r || s2_free;
  assign in_ch.ready = s1_free;
  assign prod_valid  = prod_valid_r;
  assign prod        = prod_r;

  always_comb begin
    max_rg  = (s1_green_r > s1_red_r) ? s1_green_r : s1_red_r;
    max_rgb = (s1_blue_r > max_rg) ? s1_blue_r : max_rg;
    raise   = (max_rgb <= cfg.low_threshold) && !s1_sat_r;
    lower   = (max_rgb >= cfg.high_threshold) || s1_sat_r;
    gain_code_nxt = gain_code_r;
    priority if (raise) begin
      if (gain_code_r != GAIN_MAX) gain_code_nxt = gain_code_r + 2'd1;
    end else if (lower) begin
      if (gain_code_r != GAIN_MIN) gain_code_nxt = gain_code_r - 2'd1;
    end else begin
      gain_code_nxt = gain_code_r;
    end
  end

  always_comb begin
    prod_nxt.prod_red   = $signed({1'b0, s1_red_r})   * cfg.coef_red;
    prod_nxt.prod_green = $signed({1'b0, s1_green_r}) * cfg.coef_green;
    prod_nxt.prod_blue  = $signed({1'b0, s1_blue_r})  * cfg.coef_blue;
    prod_nxt.prod_clear = $signed({1'b0, s1_clear_r}) * cfg.coef_clear;
    prod_nxt.gain_used  = gain_code_r;
    prod_nxt.gain_next  = gain_code_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      prod_valid_r <= 1'b0;
      gain_code_r  <= GAIN_MIN;
    end else begin
      if (s1_free) s1_valid_r <= in_ch.valid;
      if (s2_free) prod_valid_r <= s1_valid_r;
      if (s1_move) gain_code_r <= gain_code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_ch.valid) begin
      s1_red_r   <= in_ch.red_count;
      s1_green_r <= in_ch.green_count;
      s1_blue_r  <= in_ch.blue_count;
      s1_clear_r <= in_ch.clear_count;
      s1_sat_r   <= in_ch.saturated;
    end
    if (s1_move) prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/rgbc_lux_back.sv -----
// ----------------------------------------------------------------------------
// rgbc_lux_back
// Sum of weighted products, clamp at zero, gain scaling and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbc_lux_back
  import rgbc_lux_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      prod_valid,
  input  wire prod_t     prod,
  output logic           prod_ready,
  rgbc_lux_out_if.source out_ch
);

  logic                    out_valid_r;
  logic [LUX_W-1:0]        lux_r;
  logic [LUX_W-1:0]        lux_nxt;
  logic [GAIN_W-1:0]       gain_used_r;
  logic [GAIN_W-1:0]       gain_next_r;
  logic signed [SUM_W-1:0] sum;
  logic [LUX_W-1:0]        lux_q;
  logic                    load;

  assign prod_ready = !out_valid_r || out_ch.ready;
  assign load       = prod_valid && prod_ready;

  always_comb begin
    sum = SUM_W'(prod.prod_red) + SUM_W'(prod.prod_green)
        + SUM_W'(prod.prod_blue) + SUM_W'(prod.prod_clear);
    lux_q = sum[Q_SHIFT +: LUX_W];
    if (sum > 0) begin
      lux_nxt = lux_q >> {prod.gain_used, 1'b0};
    end else begin
      lux_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (prod_ready) begin
      out_valid_r <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lux_r       <= lux_nxt;
      gain_used_r <= prod.gain_used;
      gain_next_r <= prod.gain_next;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.lux_value = lux_r;
  assign out_ch.gain_used = gain_used_r;
  assign out_ch.gain_next = gain_next_r;

endmodule

`default_nettype wire

// ----- rtl/rgbc_lux_autogain.sv -----
// ----------------------------------------------------------------------------
// rgbc_lux_autogain
// RGBC illuminance with automatic analog gain ranging.
// Throughput: one sample per cycle while out_ch.ready keeps the pipe moving,
//   set by the three-register pipeline (input, products, result) with the
//   gain code updated in the first stage.
// Reset: synchronous, active low; pipeline empty, gain 1x, registers to
//   their default coefficients and thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbc_lux_autogain
  import rgbc_lux_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rgbc_lux_in_if.sink                in_ch,
  rgbc_lux_out_if.source             out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t  cfg_r;
  logic  prod_valid;
  prod_t prod;
  logic  prod_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_red       <= COEF_RED_RST;
      cfg_r.coef_green     <= COEF_GREEN_RST;
      cfg_r.coef_blue      <= COEF_BLUE_RST;
      cfg_r.coef_clear     <= COEF_CLEAR_RST;
      cfg_r.low_threshold  <= LOW_THR_RST;
      cfg_r.high_threshold <= HIGH_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COEF_RED:   cfg_r.coef_red       <= cfg_wdata[COEF_W-1:0];
        CFG_COEF_GREEN: cfg_r.coef_green     <= cfg_wdata[COEF_W-1:0];
        CFG_COEF_BLUE:  cfg_r.coef_blue      <= cfg_wdata[COEF_W-1:0];
        CFG_COEF_CLEAR: cfg_r.coef_clear     <= cfg_wdata[COEF_W-1:0];
        CFG_LOW_THR:    cfg_r.low_threshold  <= cfg_wdata[THR_W-1:0];
        CFG_HIGH_THR:   cfg_r.high_threshold <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  rgbc_lux_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .prod_valid (prod_valid),
    .prod       (prod),
    .prod_ready (prod_ready)
  );

  rgbc_lux_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .prod_valid (prod_valid),
    .prod       (prod),
    .prod_ready (prod_ready),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ----- test/tb_rgbc_lux_autogain.sv -----
// ----------------------------------------------------------------------------
// tb_rgbc_lux_autogain
// Self-checking bench for the RGBC lux block with automatic gain ranging.
// A short directed run walks the gain code through both ends and each
// threshold edge. Random runs then follow under several register settings,
// the extreme ones among them. Every sample transferred in is run through a
// local lux and gain predictor. Every result transferred out is compared
// field by field with the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------

module tb_rgbc_lux_autogain
  import rgbc_lux_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 11;
  localparam int MAX_REPORTS  = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    logic [COUNT_W-1:0] red;
    logic [COUNT_W-1:0] green;
    logic [COUNT_W-1:0] blue;
    logic [COUNT_W-1:0] clear;
    logic               sat;
  } sample_t;

  typedef struct {
    logic [LUX_W-1:0]  lux;
    logic [GAIN_W-1:0] used;
    logic [GAIN_W-1:0] next;
  } lux_res_t;

  class lux_checker;
    logic signed [COEF_W-1:0] k_red, k_green, k_blue, k_clear;
    logic [THR_W-1:0]         low_thr, high_thr;
    logic [GAIN_W-1:0]        gain;
    lux_res_t                 lux_due[$];
    int                       errors;

    function new();
      k_red    = COEF_RED_RST;
      k_green  = COEF_GREEN_RST;
      k_blue   = COEF_BLUE_RST;
      k_clear  = COEF_CLEAR_RST;
      low_thr  = LOW_THR_RST;
      high_thr = HIGH_THR_RST;
      gain     = GAIN_MIN;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_COEF_RED:   k_red    = d[COEF_W-1:0];
        CFG_COEF_GREEN: k_green  = d[COEF_W-1:0];
        CFG_COEF_BLUE:  k_blue   = d[COEF_W-1:0];
        CFG_COEF_CLEAR: k_clear  = d[COEF_W-1:0];
        CFG_LOW_THR:    low_thr  = d[THR_W-1:0];
        CFG_HIGH_THR:   high_thr = d[THR_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return lux_due.size();
    endfunction

    function void note_sample(sample_t s);
      logic [COUNT_W-1:0] peak;
      longint             acc;
      lux_res_t           e;
      peak = s.red;
      if (s.green > peak) peak = s.green;
      if (s.blue > peak) peak = s.blue;
      e.used = gain;
      e.next = gain;
      if (peak <= low_thr && !s.sat) begin
        if (gain != GAIN_MAX) e.next = gain + 1'b1;
      end else if (peak >= high_thr || s.sat) begin
        if (gain != GAIN_MIN) e.next = gain - 1'b1;
      end
      gain = e.next;
      acc = longint'(s.red) * longint'(k_red) + longint'(s.green) * longint'(k_green)
          + longint'(s.blue) * longint'(k_blue) + longint'(s.clear) * longint'(k_clear);
      e.lux = '0;
      if (acc > 0) e.lux = LUX_W'((acc >> Q_SHIFT) >> (2 * e.used));
      lux_due.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void check_lux(lux_res_t got);
      lux_res_t want;
      if (lux_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with none pending, expected nothing got lux_value %0d",
                   $time, got.lux);
        return;
      end
      want = lux_due.pop_front();
      compare_field("lux_value", 32'(want.lux), 32'(got.lux));
      compare_field("gain_used", 32'(want.used), 32'(got.used));
      compare_field("gain_next", 32'(want.next), 32'(got.next));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rgbc_lux_in_if  in_ch();
  rgbc_lux_out_if out_ch();

  lux_checker sb = new();

  rgbc_lux_autogain DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic sample_t rgbc(input int r, input int g, input int b, input int c,
                                   input bit sat);
    sample_t s;
    s.red   = COUNT_W'(r);
    s.green = COUNT_W'(g);
    s.blue  = COUNT_W'(b);
    s.clear = COUNT_W'(c);
    s.sat   = sat;
    return s;
  endfunction

  // steer the peak color below, between or above the thresholds
  function automatic sample_t random_sample();
    sample_t            s;
    int                 pick;
    int                 which;
    logic [COUNT_W-1:0] lo, hi, hot;
    lo = sb.low_thr;
    hi = sb.high_thr;
    s.red   = COUNT_W'($urandom);
    s.green = COUNT_W'($urandom);
    s.blue  = COUNT_W'($urandom);
    s.clear = COUNT_W'($urandom);
    pick  = $urandom_range(0, 9);
    which = $urandom_range(0, 2);
    if (pick <= 3) begin
      s.red   = COUNT_W'($urandom_range(0, lo));
      s.green = COUNT_W'($urandom_range(0, lo));
      s.blue  = COUNT_W'($urandom_range(0, lo));
    end else if (pick <= 5) begin
      hot = COUNT_W'($urandom_range(hi, 65535));
      case (which)
        0: s.red = hot;
        1: s.green = hot;
        default: s.blue = hot;
      endcase
    end else if (pick <= 7 && int'(lo) + 1 < int'(hi)) begin
      s.red   = COUNT_W'($urandom_range(0, hi - 1));
      s.green = COUNT_W'($urandom_range(0, hi - 1));
      s.blue  = COUNT_W'($urandom_range(0, hi - 1));
      hot = COUNT_W'($urandom_range(lo + 1, hi - 1));
      case (which)
        0: s.red = hot;
        1: s.green = hot;
        default: s.blue = hot;
      endcase
    end
    if ($urandom_range(0, 1) == 0) s.clear = COUNT_W'($urandom_range(0, s.green));
    s.sat = ($urandom_range(0, 7) == 0);
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    in_ch.valid       <= 1'b1;
    in_ch.red_count   <= s.red;
    in_ch.green_count <= s.green;
    in_ch.blue_count  <= s.blue;
    in_ch.clear_count <= s.clear;
    in_ch.saturated   <= s.sat;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_sample(s);
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] k_r, input logic [CFG_DATA_W-1:0] k_g,
                              input logic [CFG_DATA_W-1:0] k_b, input logic [CFG_DATA_W-1:0] k_c,
                              input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi);
    write_reg(CFG_COEF_RED, k_r);
    write_reg(CFG_COEF_GREEN, k_g);
    write_reg(CFG_COEF_BLUE, k_b);
    write_reg(CFG_COEF_CLEAR, k_c);
    write_reg(CFG_LOW_THR, lo);
    write_reg(CFG_HIGH_THR, hi);
    write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int n);
    int sent;
    int burst;
    int gap;
    int hold_at;
    sent    = 0;
    hold_at = $urandom_range(n / 4, 3 * n / 4);
    while (sent < n) begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < n) begin
          send_sample(random_sample());
          sent++;
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (hold_at > 0 && sent >= hold_at) begin
        // hold until the pipe is empty
        in_ch.valid <= 1'b0;
        settle();
        hold_at = 0;
      end else if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin : rx_side
    int       mode;
    int       span;
    int       tick;
    lux_res_t got;
    mode = 0;
    span = 0;
    tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.lux  = out_ch.lux_value;
        got.used = out_ch.gain_used;
        got.next = out_ch.gain_next;
        sb.check_lux(got);
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(16, 160);
      end
      span--;
      tick++;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (tick % 4 != 0);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin : stimulus
    int lo;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.red_count   <= '0;
    in_ch.green_count <= '0;
    in_ch.blue_count  <= '0;
    in_ch.clear_count <= '0;
    in_ch.saturated   <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_COEF_RED;
    cfg_wdata         <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: climb to the top, fall to the bottom, hit each edge
    send_sample(rgbc(0, 0, 0, 0, 0));
    send_sample(rgbc(0, 0, 0, 0, 0));
    send_sample(rgbc(8191, 8191, 8191, 0, 0));
    send_sample(rgbc(0, 0, 0, 0, 0));
    send_sample(rgbc(0, 49150, 0, 0, 0));
    send_sample(rgbc(65535, 65535, 65535, 65535, 0));
    send_sample(rgbc(0, 0, 0, 0, 1));
    send_sample(rgbc(0, 49151, 0, 0, 0));
    send_sample(rgbc(0, 65535, 0, 0, 0));
    send_sample(rgbc(8192, 0, 0, 0, 0));
    send_sample(rgbc(65535, 0, 0, 0, 0));
    send_sample(rgbc(0, 0, 65535, 0, 0));
    send_sample(rgbc(20000, 30000, 10000, 5000, 1));
    send_sample(rgbc(0, 8191, 0, 65535, 0));
    send_sample(rgbc(0, 0, 8191, 0, 0));
    send_sample(rgbc(8191, 0, 0, 0, 0));
    send_sample(rgbc(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 0));
    send_sample(rgbc(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1));
    send_sample(rgbc(40000, 48000, 30000, 1000, 0));
    send_sample(rgbc(65535, 65535, 65535, 0, 0));
    in_ch.valid <= 1'b0;
    run_random(300);
    settle();

    // largest weights, raise only on a dark sample, lower only at full scale
    program_regs(16'h3FFF, 16'h3FFF, 16'h3FFF, 16'h3FFF, 16'h0000, 16'hFFFF);
    send_sample(rgbc(0, 0, 0, 0, 0));
    send_sample(rgbc(65535, 65535, 65535, 65535, 0));
    in_ch.valid <= 1'b0;
    run_random(200);
    settle();

    // most negative weights, thresholds crossed over
    program_regs(16'hC000, 16'h4000, 16'hC000, 16'h4000, 16'hFFFF, 16'h0000);
    run_random(200);
    settle();

    // equal thresholds: the raise test wins on an exact hit
    program_regs(16'h3FFF, 16'h4000, 16'h0000, 16'h7FFF, 16'd30000, 16'd30000);
    send_sample(rgbc(0, 30000, 0, 0, 0));
    send_sample(rgbc(30000, 0, 0, 0, 1));
    send_sample(rgbc(0, 0, 30001, 0, 0));
    send_sample(rgbc(29999, 0, 0, 65535, 0));
    in_ch.valid <= 1'b0;
    run_random(200);
    settle();

    repeat (5) begin
      lo = $urandom_range(0, 40000);
      program_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                   CFG_DATA_W'($urandom), CFG_DATA_W'(lo),
                   CFG_DATA_W'($urandom_range(lo, 65535)));
      run_random(160);
      settle();
    end

    program_regs(CFG_DATA_W'(COEF_RED_RST), CFG_DATA_W'(COEF_GREEN_RST),
                 CFG_DATA_W'(COEF_BLUE_RST), CFG_DATA_W'(COEF_CLEAR_RST),
                 CFG_DATA_W'(LOW_THR_RST), CFG_DATA_W'(HIGH_THR_RST));
    run_random(100);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rgbc_lux_pkg.sv
rtl/rgbc_lux_if.sv
rtl/rgbc_lux_front.sv
rtl/rgbc_lux_back.sv
rtl/rgbc_lux_autogain.sv
test/tb_rgbc_lux_autogain.sv
